// ===== src/rdq_pkg.sv =====
// Package for the reversible deque: operation codes, sizes and the
// request, response and status struct types. No dependencies.
`default_nettype none

package rdq_pkg;

   // Operation codes carried in the kind field
   localparam logic [1:0] KIND_PUT_HEAD = 2'd0;
   localparam logic [1:0] KIND_PUT_TAIL = 2'd1;
   localparam logic [1:0] KIND_REMOVE   = 2'd2;
   localparam logic [1:0] KIND_REVERSE  = 2'd3;

   // Default number of ring slots
   localparam int DEPTH_DEFAULT = 16;

   // Field widths of the request and response
   localparam int KIND_W  = 2;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic signed [VALUE_W-1:0] value;
   } rdq_req_type;

   typedef struct packed {
      logic                      accepted;
      logic signed [VALUE_W-1:0] removed_value;
      logic [COUNT_W-1:0]        count;
   } rdq_rsp_type;

   // Outcome of one operation, handed from the control to the response stage
   typedef struct packed {
      logic accepted;   // operation succeeded
      logic took_entry; // successful remove: read data becomes the result
   } rdq_status_type;

endpackage

`default_nettype wire

// ===== src/rdq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module rdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/rdq_ctrl.sv =====
// Ring pointer control of the reversible deque: front slot, entry count,
// orientation flag and the slot address for the store. Uses rdq_pkg.
`default_nettype none

module rdq_ctrl
   import rdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              take,
   input  wire rdq_req_type       req_item,
   output logic                   ram_wr_en,
   output logic                   ram_rd_en,
   output logic [IDX_W-1:0]       ram_addr,
   output rdq_status_type         status,
   output logic [CNT_W-1:0]       count
);

   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
   localparam logic [CNT_W:0]   WRAP_SUM  = (CNT_W + 1)'(DEPTH);

   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rev_ff, rev_in;

   logic             full;
   logic             empty;
   logic [IDX_W-1:0] front_dec;
   logic [IDX_W-1:0] front_inc;
   logic [CNT_W-1:0] tail_off;
   logic [CNT_W:0]   tail_sum;
   logic [IDX_W-1:0] tail_slot;
   logic             at_front;

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);

   // Neighbor slots of the front, wrapping around the ring
   assign front_dec = (front_ff == '0) ? LAST_SLOT : front_ff - 1'b1;
   assign front_inc = (front_ff == LAST_SLOT) ? '0 : front_ff + 1'b1;

   // Slot past the back (insert) or last occupied slot (reversed remove)
   assign tail_off  = (req_item.kind == KIND_REMOVE) ? count_ff - 1'b1 : count_ff;
   assign tail_sum  = (CNT_W + 1)'(front_ff) + (CNT_W + 1)'(tail_off);
   assign tail_slot = (tail_sum >= WRAP_SUM) ? IDX_W'(tail_sum - WRAP_SUM)
                                             : IDX_W'(tail_sum);

   // Insert lands at the ring front when head and orientation agree
   assign at_front = (req_item.kind == KIND_PUT_HEAD) == !rev_ff;

   // Next state and store access for one operation
   always_comb begin
      front_in        = front_ff;
      count_in        = count_ff;
      rev_in          = rev_ff;
      ram_wr_en       = 1'b0;
      ram_rd_en       = 1'b0;
      ram_addr        = tail_slot;
      status.accepted   = 1'b0;
      status.took_entry = 1'b0;
      case (req_item.kind)
         KIND_PUT_HEAD, KIND_PUT_TAIL: begin
            if (!full) begin
               ram_wr_en       = take;
               count_in        = count_ff + 1'b1;
               status.accepted = 1'b1;
               if (at_front) begin
                  front_in = front_dec;
                  ram_addr = front_dec;
               end
            end
         end
         KIND_REMOVE: begin
            if (!empty) begin
               ram_rd_en         = take;
               count_in          = count_ff - 1'b1;
               status.accepted   = 1'b1;
               status.took_entry = 1'b1;
               if (!rev_ff) begin
                  ram_addr = front_ff;
                  front_in = front_inc;
               end
            end
         end
         default: begin
            rev_in          = !rev_ff;
            status.accepted = 1'b1;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
      end else if (take) begin
         front_ff <= front_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
      end
   end

   assign count = count_ff;

endmodule

`default_nettype wire

// ===== src/reversible_deque_queue_unit.sv =====
// Reversible bounded deque of signed 32-bit values, top level.
// Result strobe in the cycle after the start transfer; one operation per cycle outside reset.
// The latency is the registered read port of the slot store (rdq_ram).
// Reset (synchronous): empty queue, normal orientation; busy is high while reset is.
// The receiver cannot stall: every result is strobed for exactly one cycle.
// Uses rdq_pkg, rdq_ctrl and rdq_ram.
`default_nettype none

module reversible_deque_queue_unit
   import rdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire rdq_req_type req_item,
   output logic             rsp_strobe,
   output rdq_rsp_type      rsp_item
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                 take;
   logic                 ram_wr_en;
   logic                 ram_rd_en;
   logic [IDX_W-1:0]     ram_addr;
   logic [VALUE_W-1:0]   ram_rd_data;
   rdq_status_type       status;
   logic [CNT_W-1:0]     count;

   logic                 strobe_ff;
   logic                 accepted_ff;
   logic                 took_entry_ff;

   // No transfer is taken while reset is applied
   assign busy = reset;
   assign take = start && !busy;

   rdq_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .req_item  (req_item),
      .ram_wr_en (ram_wr_en),
      .ram_rd_en (ram_rd_en),
      .ram_addr  (ram_addr),
      .status    (status),
      .count     (count)
   );

   rdq_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (req_item.value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   // Result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= take;
      end
   end

   // Result status, lined up with the registered store read
   always_ff @(posedge clock) begin
      if (take) begin
         accepted_ff   <= status.accepted;
         took_entry_ff <= status.took_entry;
      end
   end

   // Count register already holds the post-operation value during the strobe
   assign rsp_strobe             = strobe_ff;
   assign rsp_item.accepted      = accepted_ff;
   assign rsp_item.removed_value = took_entry_ff ? ram_rd_data : '0;
   assign rsp_item.count         = COUNT_W'(count);

   // Every transfer gives exactly one strobe in the next cycle
   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_strobe)
      else $error("result strobe missing after a transfer");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !take |=> !rsp_strobe)
      else $error("result strobe without a transfer");

   // Count never exceeds the ring size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= CNT_W'(DEPTH))
      else $error("entry count above ring size");

   // A failed operation returns no value
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.accepted |-> rsp_item.removed_value == '0)
      else $error("failed operation carries a removed value");

endmodule

`default_nettype wire

// ===== tb/sv/reversible_deque_queue_unit_test.sv =====
// Self-checking test of reversible_deque_queue_unit: directed and random
// head/tail inserts, removes and reversals, predicted transfer by transfer.
// Depends on rdq_pkg and the reversible_deque_queue_unit RTL.
`default_nettype none

// Tracks the deque contents and holds the results still owed by the block
class rdq_deque_tracker;
   localparam int SLOTS  = rdq_pkg::DEPTH_DEFAULT;
   localparam int SLOT_W = $clog2(SLOTS);

   logic [31:0]       ring [SLOTS];
   logic [SLOT_W-1:0] front;
   logic [4:0]        held;
   logic              flipped;

   rdq_pkg::rdq_rsp_type owed_q [$];

   int errors;
   int transfers;
   int full_rejects;
   int empty_rejects;
   int reversals;
   int results_seen;

   function new();
      front         = '0;
      held          = '0;
      flipped       = 1'b0;
      errors        = 0;
      transfers     = 0;
      full_rejects  = 0;
      empty_rejects = 0;
      reversals     = 0;
      results_seen  = 0;
   endfunction

   task report(input string msg);
      errors++;
      $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   function int pending();
      return owed_q.size();
   endfunction

   // Work out the result of one accepted transfer and queue it
   function void note_transfer(input rdq_pkg::rdq_req_type req);
      rdq_pkg::rdq_rsp_type owed;
      logic                 at_front;
      logic [SLOT_W-1:0]    slot;
      owed = '0;
      transfers++;
      case (req.kind)
         rdq_pkg::KIND_PUT_HEAD, rdq_pkg::KIND_PUT_TAIL: begin
            // head is the ring front unless the order is flipped
            at_front = (req.kind == rdq_pkg::KIND_PUT_HEAD) ^ flipped;
            if (held < SLOTS) begin
               if (at_front) begin
                  front = front - 1'b1;
                  ring[front] = req.value;
               end else begin
                  slot = front + held[SLOT_W-1:0];
                  ring[slot] = req.value;
               end
               held++;
               owed.accepted = 1'b1;
            end else begin
               full_rejects++;
            end
         end
         rdq_pkg::KIND_REMOVE: begin
            if (held != 0) begin
               if (!flipped) begin
                  owed.removed_value = ring[front];
                  front = front + 1'b1;
               end else begin
                  slot = front + held[SLOT_W-1:0] - 1'b1;
                  owed.removed_value = ring[slot];
               end
               held--;
               owed.accepted = 1'b1;
            end else begin
               empty_rejects++;
            end
         end
         default: begin
            flipped = ~flipped;
            owed.accepted = 1'b1;
            reversals++;
         end
      endcase
      owed.count = held;
      owed_q.push_back(owed);
   endfunction

   // Compare one strobed result with the oldest owed one
   task check_result(input rdq_pkg::rdq_rsp_type got);
      rdq_pkg::rdq_rsp_type owed;
      results_seen++;
      if (owed_q.size() == 0) begin
         report($sformatf("result with nothing owed: acc=%0b val=%0d count=%0d",
                          got.accepted, got.removed_value, got.count));
      end else begin
         owed = owed_q.pop_front();
         if (got.accepted !== owed.accepted)
            report($sformatf("accepted %b, predicted %b", got.accepted, owed.accepted));
         if (got.removed_value !== owed.removed_value)
            report($sformatf("removed_value %0d, predicted %0d",
                             got.removed_value, owed.removed_value));
         if (got.count !== owed.count)
            report($sformatf("count %0d, predicted %0d", got.count, owed.count));
      end
   endtask

   task finish_check();
      if (owed_q.size() != 0)
         report($sformatf("%0d results never arrived", owed_q.size()));
   endtask
endclass

module reversible_deque_queue_unit_test;
   import rdq_pkg::*;

   localparam int RANDOM_ITEMS = 1900;
   localparam int QUIET_FIRST  = 900;
   localparam int QUIET_LAST   = 1200;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   rdq_req_type req_item;
   logic        rsp_strobe;
   rdq_rsp_type rsp_item;

   rdq_deque_tracker tracker;

   reversible_deque_queue_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Run limit, far above the slowest correct run
   initial begin
      #(400_000 * 4);
      $display("CHECK FAILED");
      $finish;
   end

   // Sample both channels at the rising edge; results first, they are older
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            tracker.check_result(rsp_item);
         if (start && !busy)
            tracker.note_transfer(req_item);
      end
   end

   // Drive one operation from a falling edge until its transfer
   task automatic send_op(input logic [1:0] kind, input logic [31:0] value,
                          input bit may_idle);
      rdq_req_type req;
      req.kind  = kind;
      req.value = value;
      if (may_idle) begin
         while ($urandom_range(0, 99) < 24) begin
            start <= 1'b0;
            @(negedge clock);
         end
      end
      start    <= 1'b1;
      req_item <= req;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Hold off the sender until every owed result has come back or the given limit runs out
   task automatic wait_drained(input int max_cycles);
      int n;
      n = 0;
      start <= 1'b0;
      do begin
         @(negedge clock);
         n++;
      end while (tracker.pending() != 0 && n < max_cycles);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return $urandom_range(0, 15);
         3:       return 32'hffff_ffff - $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int          fill_pct;
      logic [1:0]  kind;
      logic [31:0] value;
      tracker  = new();
      start    = 1'b0;
      req_item = '0;
      reset    = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty corner cases, one entry, then fill past full
      send_op(KIND_REMOVE,   32'h0,         0);
      send_op(KIND_REVERSE,  32'h0,         0);
      send_op(KIND_PUT_HEAD, 32'h8000_0000, 0);
      send_op(KIND_REVERSE,  32'h0,         0);
      send_op(KIND_REMOVE,   32'h0,         0);
      for (int i = 0; i < 16; i++) begin
         case (i % 4)
            0: value = 32'h7fff_ffff;
            1: value = 32'h8000_0000;
            2: value = 32'hffff_ffff;
            default: value = 32'h0 + i;
         endcase
         send_op((i % 2 == 0) ? KIND_PUT_HEAD : KIND_PUT_TAIL, value, 0);
      end
      send_op(KIND_PUT_TAIL, 32'h1234_5678, 0);
      send_op(KIND_PUT_HEAD, 32'hdead_beef, 0);
      send_op(KIND_REVERSE,  32'h0,         0);
      send_op(KIND_REMOVE,   32'h0,         0);
      wait_drained(100);

      // Random: insert bias swings per segment so the store runs full and dry
      fill_pct = 50;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(0, 3))
               0:       fill_pct = 85;
               1:       fill_pct = 15;
               2:       fill_pct = 50;
               default: fill_pct = 60;
            endcase
         end
         if (i == RANDOM_ITEMS / 2)
            wait_drained(100);
         if ($urandom_range(0, 99) < 10)
            kind = KIND_REVERSE;
         else if ($urandom_range(0, 99) < fill_pct)
            kind = $urandom_range(0, 1) ? KIND_PUT_HEAD : KIND_PUT_TAIL;
         else
            kind = KIND_REMOVE;
         send_op(kind, pick_value(), !(i >= QUIET_FIRST && i < QUIET_LAST));
      end

      // Drain, let the pipeline settle, then judge
      wait_drained(200);
      repeat (4) @(posedge clock);
      tracker.finish_check();
      $display("Ran %0d operations with %0d results checked: %0d reversals,",
               tracker.transfers, tracker.results_seen, tracker.reversals);
      $display("%0d inserts refused while full, %0d removes refused while empty.",
               tracker.full_rejects, tracker.empty_rejects);
      if (tracker.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

`default_nettype wire

// ===== reversible_deque_queue_unit.f =====
src/rdq_pkg.sv
src/rdq_ram.sv
src/rdq_ctrl.sv
src/reversible_deque_queue_unit.sv
tb/sv/reversible_deque_queue_unit_test.sv
